@@ hw/rtl/ftc_pkg.sv @@
// ----------------------------------------------------------------------------
// ftc_pkg: shared types and constants for the type cast pipeline
// Type codes, config indices, operation codes, stage payload structs.
// ----------------------------------------------------------------------------
package ftc_pkg;

  localparam logic [1:0] TYPE_F32 = 2'd0;
  localparam logic [1:0] TYPE_I32 = 2'd1;
  localparam logic [1:0] TYPE_I64 = 2'd2;
  localparam logic [1:0] TYPE_BAD = 2'd3;

  localparam logic [0:0] CFG_SRC = 1'b0;
  localparam logic [0:0] CFG_DST = 1'b1;

  typedef enum logic [2:0] {
    OP_COPY = 3'b001,
    OP_F2I  = 3'b010,
    OP_I2F  = 3'b100
  } op_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        last;
    logic        status;
    op_t         op;
    logic        wide;   // integer target/source is int64
    logic [63:0] copy;   // finished result for copy / int-int / error
    // float to int
    logic        fsign;
    logic        fzero;
    logic        fsat;
    logic [5:0]  fexp;   // unbiased exponent 0..62
    logic [23:0] fsig;
    // int to float
    logic        isign;
    logic [63:0] imag;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic        last;
    logic        status;
    op_t         op;
    logic        wide;
    logic [63:0] copy;
    logic        fsign;
    logic        fzero;
    logic        fsat;
    logic [63:0] fmag;
    logic        isign;
    logic        izero;
    logic [5:0]  ipos;   // msb position
    logic [63:0] inorm;  // magnitude shifted so msb at bit 63
  } s2_t;

endpackage

@@ hw/rtl/ftc_decode.sv @@
// ----------------------------------------------------------------------------
// ftc_decode: stage 1, operation select and field unpack
// Picks the operation from the type registers and splits the source word.
// ----------------------------------------------------------------------------
module ftc_decode (
  input  logic [1:0]     src_type,
  input  logic [1:0]     dst_type,
  input  logic [63:0]    bits,
  input  logic           last,
  output ftc_pkg::s1_t   s1
);
  import ftc_pkg::*;

  logic [31:0] lo;
  logic [7:0]  e8;
  logic [63:0] ival;

  always_comb begin
    lo   = bits[31:0];
    e8   = lo[30:23];
    ival = (src_type == TYPE_I32) ? {{32{lo[31]}}, lo} : bits;
    s1 = '0;
    s1.last   = last;
    s1.op     = OP_COPY;
    s1.wide   = (dst_type == TYPE_I64) || (src_type == TYPE_I64);
    s1.fsign  = lo[31];
    s1.fsig   = {1'b1, lo[22:0]};
    s1.fzero  = (e8 < 8'd127) || (e8 == 8'hFF && lo[22:0] != '0);
    s1.fsat   = (e8 >= 8'd127) &&
                ((dst_type == TYPE_I64) ? (e8 >= 8'd190) : (e8 >= 8'd158));
    s1.fexp   = 6'(e8 - 8'd127);
    s1.isign  = ival[63];
    s1.imag   = ival[63] ? (64'd0 - ival) : ival;
    if (src_type == TYPE_BAD || dst_type == TYPE_BAD) begin
      s1.status = 1'b1;
    end else if (src_type == dst_type) begin
      s1.copy = (src_type == TYPE_I64) ? bits : {32'd0, lo};
    end else if (src_type == TYPE_F32) begin
      s1.op = OP_F2I;
    end else if (dst_type == TYPE_F32) begin
      s1.op = OP_I2F;
    end else if (src_type == TYPE_I32) begin
      s1.copy = {{32{lo[31]}}, lo};
    end else begin
      s1.copy = {32'd0, lo};
    end
  end

endmodule

@@ hw/rtl/ftc_shift.sv @@
// ----------------------------------------------------------------------------
// ftc_shift: stage 2, barrel shifts
// Float significand placed by exponent; integer magnitude normalised.
// ----------------------------------------------------------------------------
module ftc_shift (
  input  ftc_pkg::s1_t s1,
  output ftc_pkg::s2_t s2
);
  import ftc_pkg::*;

  logic [5:0] lz;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (s1.imag[i]) lz = 6'(63 - i);
    end
    s2.last   = s1.last;
    s2.status = s1.status;
    s2.op     = s1.op;
    s2.wide   = s1.wide;
    s2.copy   = s1.copy;
    s2.fsign  = s1.fsign;
    s2.fzero  = s1.fzero;
    s2.fsat   = s1.fsat;
    // sig has its msb at bit 23; value = sig * 2^(exp-23)
    s2.fmag   = (s1.fexp >= 6'd23) ? ({40'd0, s1.fsig} << (s1.fexp - 6'd23))
                                   : ({40'd0, s1.fsig} >> (6'd23 - s1.fexp));
    s2.isign  = s1.isign;
    s2.izero  = (s1.imag == '0);
    s2.ipos   = 6'd63 - lz;
    s2.inorm  = s1.imag << lz;
  end

endmodule

@@ hw/rtl/ftc_pack.sv @@
// ----------------------------------------------------------------------------
// ftc_pack: stage 3, rounding, saturation and result assembly
// ----------------------------------------------------------------------------
module ftc_pack (
  input  ftc_pkg::s2_t s2,
  output logic [63:0]  result
);
  import ftc_pkg::*;

  logic [63:0] ival;
  logic [24:0] mant;
  logic        rnd;
  logic [7:0]  expo;
  logic [31:0] fbits;

  always_comb begin
    // float to int
    if (s2.fzero) ival = '0;
    else if (s2.fsat)
      ival = s2.wide ? (s2.fsign ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                     : (s2.fsign ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF);
    else ival = s2.fsign ? (64'd0 - s2.fmag) : s2.fmag;
    if (!s2.wide) ival = {32'd0, ival[31:0]};
    // int to float, nearest even; guard at bit 39, sticky below
    rnd  = s2.inorm[39] && ((s2.inorm[38:0] != '0) || s2.inorm[40]);
    mant = {1'b0, s2.inorm[63:40]} + {24'd0, rnd};
    expo = 8'(s2.ipos) + 8'd127 + {7'd0, mant[24]};
    fbits = s2.izero ? 32'd0 : {s2.isign, expo, mant[24] ? mant[23:1] : mant[22:0]};
    unique case (s2.op)
      OP_F2I:  result = ival;
      OP_I2F:  result = {32'd0, fbits};
      default: result = s2.copy;
    endcase
    if (s2.status) result = '0;
  end

endmodule

@@ hw/rtl/fp32_int_type_cast_top.sv @@
// ----------------------------------------------------------------------------
// fp32_int_type_cast_top: float32 / int32 / int64 element type cast
// Three-stage pipeline converting one element per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//  in_*  stream: tdata = element_bits[63:0], tlast = element_last.
//  out_* stream: tdata = result_bits[63:0], tlast = result_last,
//                tuser = cast_status.
//  cfg_*: write index 0 source type, 1 target type (0 f32, 1 i32, 2 i64).
//  Each input word passes the decode stage, shift stage and round/pack
//  stage, each registered, before it reaches the output. Throughput one
//  word per cycle while out_tready does not stall the pipeline.
//  Stalls: the pipeline advances only when the output register is free or
//  being taken, so a held out_tready freezes all stages with no loss.
//  Reset clears the valid bits and sets both types to float32.
//  Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module fp32_int_type_cast_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // element_bits
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result_bits
  output logic        out_tlast,
  output logic        out_tuser,  // cast_status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [1:0]  cfg_data
);
  import ftc_pkg::*;

  logic [1:0] src_r, dst_r;
  logic v1_r, v2_r, v3_r;
  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  logic [63:0] res_nxt, res_r;
  logic last_r, stat_r;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !v3_r || out_tready;
  assign in_tready = adv;

  ftc_decode u_dec (.src_type(src_r), .dst_type(dst_r), .bits(in_tdata),
                    .last(in_tlast), .s1(s1_nxt));
  ftc_shift  u_sh  (.s1(s1_r), .s2(s2_nxt));
  ftc_pack   u_pk  (.s2(s2_r), .result(res_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= TYPE_F32;
      dst_r <= TYPE_F32;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_SRC) src_r <= cfg_data;
        else dst_r <= cfg_data;
      end
      if (adv) begin
        v1_r <= in_tvalid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      res_r  <= res_nxt;
      last_r <= s2_r.last;
      stat_r <= s2_r.status;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = res_r;
  assign out_tlast  = last_r;
  assign out_tuser  = stat_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("error word carries data");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("pipeline blocked while output empty");

endmodule
